[hdl/sust_pkg.sv]
package sust_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_ABSENT    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  count;
        logic [31:0] entry_value;
    } sust_res_t;

endpackage

[hdl/sust_mem.sv]
module sust_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sust_seq.sv]
module sust_seq #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_cmd,
    input  logic [31:0]                 in_value,
    input  logic [3:0]                  in_index,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sust_pkg::sust_res_t         res,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [VALUE_WIDTH-1:0]      mem_wr_data,
    output logic                        mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [VALUE_WIDTH-1:0]      mem_rd_data
);

    import sust_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_INS_RD = 4'd3;
    localparam logic [3:0] S_INS_WR = 4'd4;
    localparam logic [3:0] S_DEL_RD = 4'd5;
    localparam logic [3:0] S_DEL_WR = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [1:0]             cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [2:0]             status_reg, status_next;
    logic [VALUE_WIDTH-1:0] ev_reg, ev_next;

    logic [VALUE_WIDTH+31:0] val_wide;
    logic [VALUE_WIDTH+31:0] ev_wide;
    logic [CW+4:0]           cnt_wide;
    logic [CW+3:0]           idx_ext;
    logic [CW+3:0]           cnt_ext;
    logic [CW-1:0]           ptr_inc;
    logic [CW-1:0]           ptr_dec;
    logic                    cmp_eq;
    logic                    cmp_lt;
    logic                    do_hit;
    logic                    do_miss;

    assign val_wide = {{VALUE_WIDTH{1'b0}}, in_value};
    assign ev_wide  = {32'b0, ev_reg};
    assign cnt_wide = {5'b0, cnt_reg};
    assign idx_ext  = {{CW{1'b0}}, in_index};
    assign cnt_ext  = {4'b0, cnt_reg};
    assign ptr_inc  = ptr_reg + ONE;
    assign ptr_dec  = ptr_reg - ONE;

    assign cmp_eq = (mem_rd_data == val_reg);
    assign cmp_lt = (mem_rd_data < val_reg);

    assign in_ready         = (state_reg == S_IDLE);
    assign res.status       = status_reg;
    assign res.count        = cnt_wide[4:0];
    assign res.entry_value  = ev_wide[31:0];

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        ev_next     = ev_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = ptr_reg[AW-1:0];
        res_valid   = 1'b0;
        do_hit      = 1'b0;
        do_miss     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_cmd;
                    val_next    = val_wide[VALUE_WIDTH-1:0];
                    ptr_next    = '0;
                    ev_next     = '0;
                    status_next = ST_OK;
                    if (in_cmd == CMD_READ) begin
                        if (idx_ext < cnt_ext) begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_ext[AW-1:0];
                            state_next  = S_READ;
                        end else begin
                            status_next = ST_BAD_INDEX;
                            state_next  = S_DONE;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ptr_reg == cnt_reg) begin
                    do_miss = 1'b1;
                end else begin
                    mem_rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (cmp_eq) begin
                    do_hit = 1'b1;
                end else if (cmp_lt) begin
                    do_miss = 1'b1;
                end else begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN;
                end
            end
            S_INS_RD: begin
                if (ptr_reg == pos_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = val_reg;
                    cnt_next    = cnt_reg + ONE;
                    state_next  = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_dec[AW-1:0];
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR: begin
                mem_wr_en  = 1'b1;
                ptr_next   = ptr_dec;
                state_next = S_INS_RD;
            end
            S_DEL_RD: begin
                if (ptr_inc == cnt_reg) begin
                    cnt_next   = cnt_reg - ONE;
                    state_next = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_inc[AW-1:0];
                    state_next  = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                mem_wr_en  = 1'b1;
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end
            S_READ: begin
                ev_next    = mem_rd_data;
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_hit) begin
            case (cmd_reg)
                CMD_ADD: begin
                    status_next = ST_PRESENT;
                    state_next  = S_DONE;
                end
                CMD_REMOVE: begin
                    state_next = S_DEL_RD;
                end
                default: begin
                    state_next = S_DONE;
                end
            endcase
        end

        if (do_miss) begin
            case (cmd_reg)
                CMD_ADD: begin
                    if (cnt_reg == CAP) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        pos_next   = ptr_reg;
                        ptr_next   = cnt_reg;
                        state_next = S_INS_RD;
                    end
                end
                default: begin
                    status_next = ST_ABSENT;
                    state_next  = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        ev_reg     <= ev_next;
    end

endmodule

[hdl/sorted_unique_set_table.sv]
// Channel  Direction  Ports                                   Carries
// s_       in         s_valid s_ready s_cmd s_value s_index   one command item
// m_       out        m_valid m_ready m_status m_count        one result item
//                     m_entry_value
//
// Steps: read fetches the indexed entry, or reports a bad index when the index
// is at or beyond the count; add, remove and search compare entries one at a
// time through one compare unit and one table read port, then add or remove
// moves each later entry one place through that read port.
// Reset: aresetn low clears the held count; table contents stay undefined.
// Stalls: a finished result waits in the output register; the next item is
// taken meanwhile and its result holds until the register frees.
module sorted_unique_set_table #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_value,
    input  logic [3:0]  s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [4:0]  m_count,
    output logic [31:0] m_entry_value
);

    import sust_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                   res_valid;
    logic                   res_ready;
    sust_res_t              res;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [VALUE_WIDTH-1:0] mem_rd_data;

    logic      m_valid_reg, m_valid_next;
    sust_res_t m_res_reg, m_res_next;

    sust_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_cmd      (s_cmd),
        .in_value    (s_value),
        .in_index    (s_index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    sust_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_count       = m_res_reg.count;
    assign m_entry_value = m_res_reg.entry_value;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a command is in progress");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_valid)
        else $error("result lost on push into output register");

    a_value_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_entry_value == 32'd0))
        else $error("entry value nonzero on failed command");

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !res_valid) |=> (m_valid && $stable(m_count)))
        else $error("stalled result changed");
`endif

endmodule
